[src/psu_pkg.sv]
// Shared types and constants for the PNG scanline unfilter.
`timescale 1ns / 1ps
package psu_pkg;

  localparam int MAX_ROW_BYTES   = 16384;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int COL_W           = $clog2(MAX_ROW_BYTES);
  localparam int PIXSEL_W        = $clog2(MAX_PIXEL_BYTES);
  localparam int ROWLEN_W        = 15;
  localparam int ROWS_W          = 16;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd2;

  localparam logic [3:0]          RST_PIXEL_BYTES = 4'd4;
  localparam logic [ROWLEN_W-1:0] RST_ROW_BYTES   = 15'd1024;
  localparam logic [ROWS_W-1:0]   RST_IMAGE_ROWS  = 16'd1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [PIXSEL_W-1:0] pix_sel;   // pixel bytes - 1
    logic [ROWLEN_W-1:0] row_len;   // 1..MAX_ROW_BYTES
    logic [ROWS_W-1:0]   rows;      // 1..65535
  } cfg_eff_t;

  // One data byte request, classified by the front end.
  typedef struct packed {
    logic [7:0]       data;
    filt_t            filter;
    logic [COL_W-1:0] col;
    logic             row_start;
    logic             first_row;
    logic             row_end;
    logic             img_end;
  } item_t;

endpackage

[src/psu_front.sv]
// Front end: consumes type bytes, tracks column/row, queues data byte requests.
`timescale 1ns / 1ps
module psu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  psu_pkg::cfg_eff_t cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_filtered_byte,
  input  logic              q_full,
  output logic              q_push,
  output psu_pkg::item_t    q_item
);

  logic                      awaiting_r, awaiting_nxt;
  logic                      row_start_r, row_start_nxt;
  psu_pkg::filt_t            filter_r, filter_nxt;
  logic [psu_pkg::COL_W-1:0] col_r, col_nxt;
  logic [psu_pkg::ROWS_W-1:0] row_r, row_nxt;
  logic                      accept;
  logic                      row_end;
  logic                      img_end;
  logic [psu_pkg::ROWLEN_W-1:0] col_inc;
  logic [psu_pkg::ROWS_W:0]  row_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign col_inc = {1'b0, col_r} + {{(psu_pkg::ROWLEN_W-1){1'b0}}, 1'b1};
  assign row_inc = {1'b0, row_r} + {{psu_pkg::ROWS_W{1'b0}}, 1'b1};
  assign row_end = (col_inc >= cfg.row_len);
  assign img_end = row_end && (row_inc >= {1'b0, cfg.rows});

  always_comb begin
    q_item.data      = in_filtered_byte;
    q_item.filter    = filter_r;
    q_item.col       = col_r;
    q_item.row_start = row_start_r;
    q_item.first_row = (row_r == '0);
    q_item.row_end   = row_end;
    q_item.img_end   = img_end;
  end

  assign q_push = accept && !awaiting_r;

  always_comb begin
    awaiting_nxt  = awaiting_r;
    row_start_nxt = row_start_r;
    filter_nxt    = filter_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    if (accept) begin
      if (awaiting_r) begin
        // type byte: codes above Paeth fall back to None
        filter_nxt    = (in_filtered_byte <= 8'd4) ? psu_pkg::filt_t'(in_filtered_byte[2:0])
                                                   : psu_pkg::FILT_NONE;
        awaiting_nxt  = 1'b0;
        row_start_nxt = 1'b1;
        col_nxt       = '0;
      end else begin
        row_start_nxt = 1'b0;
        if (row_end) begin
          awaiting_nxt = 1'b1;
          col_nxt      = '0;
          row_nxt      = img_end ? '0 : row_inc[psu_pkg::ROWS_W-1:0];
        end else begin
          col_nxt = col_inc[psu_pkg::COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r  <= 1'b1;
      row_start_r <= 1'b1;
      filter_r    <= psu_pkg::FILT_NONE;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      awaiting_r  <= awaiting_nxt;
      row_start_r <= row_start_nxt;
      filter_r    <= filter_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
    end
  end

endmodule

[src/psu_queue.sv]
// Short request queue between front end and back end.
`timescale 1ns / 1ps
module psu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psu_pkg::item_t push_item,
  output logic           full,
  output logic           not_empty,
  input  logic           pop,
  output psu_pkg::item_t pop_item
);

  psu_pkg::item_t              slot_r [psu_pkg::QDEPTH];
  logic [psu_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [psu_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [psu_pkg::QPTR_W:0]    count_r, count_nxt;

  assign full      = (count_r == (psu_pkg::QPTR_W+1)'(psu_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (push ? 1'b1 : 1'b0);
    rd_ptr_nxt = rd_ptr_r + (pop ? 1'b1 : 1'b0);
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[src/psu_back.sv]
// Back end: line store read, filter reconstruction, output register.
`timescale 1ns / 1ps
module psu_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [psu_pkg::PIXSEL_W-1:0] pix_sel,
  input  logic                         q_not_empty,
  output logic                         q_pop,
  input  psu_pkg::item_t               q_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_pixel_byte,
  output logic                         out_end_of_row,
  output logic                         out_last_of_image
);

  logic [7:0] line_mem [psu_pkg::MAX_ROW_BYTES];

  // reconstruct stage
  logic           b_valid_r;
  psu_pkg::item_t b_item_r;
  logic [7:0]     rd_data_r;
  logic           fwd_r;
  logic [7:0]     fwd_data_r;

  logic [63:0] left_hist_r, left_hist_nxt;
  logic [63:0] ul_hist_r, ul_hist_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_eor_r;
  logic       out_eoi_r;

  logic        b_fire;
  logic        b_load;
  logic [63:0] left_cur;
  logic [63:0] ul_cur;
  logic [7:0]  a, b, c, pred, r;
  logic [8:0]  avg_sum;
  logic signed [9:0] da, db, dsum;
  logic [9:0]  pa, pb, pc;

  assign b_fire = b_valid_r && (!out_valid_r || !out_stall);
  assign b_load = q_not_empty && (!b_valid_r || b_fire);
  assign q_pop  = b_load;

  // history restarts at each row
  assign left_cur = b_item_r.row_start ? '0 : left_hist_r;
  assign ul_cur   = b_item_r.row_start ? '0 : ul_hist_r;
  assign a = left_cur[{pix_sel, 3'b000} +: 8];
  assign c = ul_cur[{pix_sel, 3'b000} +: 8];
  assign b = b_item_r.first_row ? 8'd0 : (fwd_r ? fwd_data_r : rd_data_r);

  assign avg_sum = {1'b0, a} + {1'b0, b};
  assign da      = $signed({2'b00, b}) - $signed({2'b00, c});
  assign db      = $signed({2'b00, a}) - $signed({2'b00, c});
  assign dsum    = da + db;
  assign pa      = da[9] ? 10'(-da) : 10'(da);
  assign pb      = db[9] ? 10'(-db) : 10'(db);
  assign pc      = dsum[9] ? 10'(-dsum) : 10'(dsum);

  always_comb begin
    case (b_item_r.filter)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      psu_pkg::FILT_PAETH: begin
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc)        pred = b;
        else                      pred = c;
      end
      default:             pred = 8'd0;
    endcase
  end

  assign r = b_item_r.data + pred;

  assign left_hist_nxt = {left_cur[55:0], r};
  assign ul_hist_nxt   = {ul_cur[55:0], b};

  always_ff @(posedge clk) begin
    if (b_fire) line_mem[b_item_r.col] <= r;
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      rd_data_r  <= line_mem[q_item.col];
      // same-column write landing on this edge: take the fresh value
      fwd_r      <= b_fire && (b_item_r.col == q_item.col);
      fwd_data_r <= r;
      b_item_r   <= q_item;
    end
    if (b_fire) begin
      out_byte_r <= r;
      out_eor_r  <= b_item_r.row_end;
      out_eoi_r  <= b_item_r.img_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      left_hist_r <= '0;
      ul_hist_r   <= '0;
    end else begin
      if (b_load)      b_valid_r <= 1'b1;
      else if (b_fire) b_valid_r <= 1'b0;
      if (b_fire)         out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (b_fire) begin
        left_hist_r <= left_hist_nxt;
        ul_hist_r   <= ul_hist_nxt;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_byte    = out_byte_r;
  assign out_end_of_row    = out_eor_r;
  assign out_last_of_image = out_eoi_r;

endmodule

[src/png_scanline_unfilter_core.sv]
// Top level of the PNG scanline unfilter: config registers, front end, queue, back end.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid / in_stall / in_filtered_byte): one filtered byte per
//   request. The first byte of each row is the filter type (None, Sub, Up,
//   Average, Paeth; other codes act as None) and yields no result.
//   Output channel (out_valid / out_stall / out_*): one reconstructed byte per
//   data byte, with end_of_row on the last byte of a row and last_of_image on the
//   last byte of the final row. After that the next input byte is row 0's type.
//   Config port (cfg_we / cfg_index / cfg_wdata): 0 pixel_bytes, 1 row_bytes,
//   2 image_rows; write only while the block is idle. Out-of-range values clamp.
// Timing
//   Sustained rate is one byte per cycle while out_stall stays low. An accepted
//   data byte passes the queue, then the line store read, whose registered data
//   feeds the filter, and then the output register.
// Reset
//   rst_n (synchronous) empties the pipeline, clears the neighbor history and
//   row/column counters, and loads pixel_bytes=4, row_bytes=1024, image_rows=1.
//   The line store is not cleared; row 0 never uses its contents.
// Backpressure
//   out_stall holds the output register; the back end and then the 4-entry queue
//   fill, and in_stall rises once the queue is full.
module png_scanline_unfilter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psu_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_filtered_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_pixel_byte,
  output logic                          out_end_of_row,
  output logic                          out_last_of_image
);

  logic [3:0]                    pixel_bytes_r;
  logic [psu_pkg::ROWLEN_W-1:0]  row_bytes_r;
  logic [psu_pkg::ROWS_W-1:0]    image_rows_r;
  psu_pkg::cfg_eff_t             cfg_eff;

  logic           q_push, q_full, q_not_empty, q_pop;
  psu_pkg::item_t q_in_item, q_out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_bytes_r <= psu_pkg::RST_PIXEL_BYTES;
      row_bytes_r   <= psu_pkg::RST_ROW_BYTES;
      image_rows_r  <= psu_pkg::RST_IMAGE_ROWS;
    end else if (cfg_we) begin
      case (cfg_index)
        psu_pkg::CFG_PIXEL_BYTES: pixel_bytes_r <= cfg_wdata[3:0];
        psu_pkg::CFG_ROW_BYTES:   row_bytes_r   <= cfg_wdata[psu_pkg::ROWLEN_W-1:0];
        psu_pkg::CFG_IMAGE_ROWS:  image_rows_r  <= cfg_wdata[psu_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to their usable ranges
  always_comb begin
    if (pixel_bytes_r == 4'd0)
      cfg_eff.pix_sel = '0;
    else if (pixel_bytes_r > 4'(psu_pkg::MAX_PIXEL_BYTES))
      cfg_eff.pix_sel = psu_pkg::PIXSEL_W'(psu_pkg::MAX_PIXEL_BYTES - 1);
    else
      cfg_eff.pix_sel = psu_pkg::PIXSEL_W'(pixel_bytes_r - 4'd1);

    if (row_bytes_r == '0)
      cfg_eff.row_len = psu_pkg::ROWLEN_W'(1);
    else if (row_bytes_r > psu_pkg::ROWLEN_W'(psu_pkg::MAX_ROW_BYTES))
      cfg_eff.row_len = psu_pkg::ROWLEN_W'(psu_pkg::MAX_ROW_BYTES);
    else
      cfg_eff.row_len = row_bytes_r;

    cfg_eff.rows = (image_rows_r == '0) ? psu_pkg::ROWS_W'(1) : image_rows_r;
  end

  psu_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_eff),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_filtered_byte (in_filtered_byte),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (q_in_item)
  );

  psu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_item  (q_out_item)
  );

  psu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pix_sel           (cfg_eff.pix_sel),
    .q_not_empty       (q_not_empty),
    .q_pop             (q_pop),
    .q_item            (q_out_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_byte    (out_pixel_byte),
    .out_end_of_row    (out_end_of_row),
    .out_last_of_image (out_last_of_image)
  );

endmodule

[tb/sv/png_scanline_unfilter_core_tb.sv]
// Self-checking testbench for the PNG scanline unfilter core.
`timescale 1ns / 1ps
module png_scanline_unfilter_core_tb;

  localparam int CLK_HALF       = 6;     // 12 ns period
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 8;     // pipeline is ~3 deep; type bytes leave no trace
  localparam int HOLD_CYCLES    = 80;    // long receiver hold-off to fill the queue
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request moving on either side
  localparam int RANDOM_ITEMS   = 750;
  localparam int DIR_ROWS       = 37;

  // Only index left free by the three registers; writes to it must be ignored.
  localparam logic [psu_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  // Filter type byte outside the defined codes; decodes as None.
  localparam logic [7:0] UNKNOWN_FILT = 8'hFF;

  typedef struct packed {
    logic [7:0] pix;
    logic       eor;
    logic       loi;
  } pix_out_t;

  // ST_CFG: register write; ST_BYTE: request checked by the predictor;
  // ST_CHECKED: request whose result is typed into the table.
  typedef enum {ST_CFG, ST_BYTE, ST_CHECKED} dir_kind_t;

  typedef struct {
    dir_kind_t                     kind;
    logic [psu_pkg::CFG_IDX_W-1:0] idx;
    logic [psu_pkg::CFG_W-1:0]     wdata;
    logic [7:0]                    din;
    pix_out_t                      res;
  } dir_row_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD} idle_mode_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [psu_pkg::CFG_W-1:0]     cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic [7:0]                    in_filtered_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [7:0]                    out_pixel_byte;
  logic                          out_end_of_row;
  logic                          out_last_of_image;

  png_scanline_unfilter_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_filtered_byte  (in_filtered_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_byte    (out_pixel_byte),
    .out_end_of_row    (out_end_of_row),
    .out_last_of_image (out_last_of_image)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the line store, neighbor history,
  // counters and registers. Advanced once per accepted request, in order.
  // ---------------------------------------------------------------------------
  logic [7:0]                   line_store [psu_pkg::MAX_ROW_BYTES];
  logic [63:0]                  left_hist;       // reconstructed bytes, newest in low byte
  logic [63:0]                  above_hist;      // above bytes, newest in low byte
  int unsigned                  col_idx;
  int unsigned                  row_idx;
  psu_pkg::filt_t               filt;
  bit                           want_type;
  int unsigned                  store_filled;    // line store written for [0, store_filled)
  logic [3:0]                   cfg_pix;
  logic [psu_pkg::ROWLEN_W-1:0] cfg_row;
  logic [psu_pkg::ROWS_W-1:0]   cfg_rows;

  pix_out_t   pending_pixels [$];  // expected results, oldest first
  pix_out_t   due_pixel;
  int         fault_count;
  int         quiet_cycles;
  int         tx_pct;              // sender idle chance, percent per cycle
  idle_mode_t rx_mode;             // receiver behavior, handed over by NBA
  dir_row_t   dir_tab [DIR_ROWS];

  // One request through the reconstruction filter. A type byte only arms the
  // row; a data byte yields one reconstructed byte plus its row/image flags.
  function automatic void unfilter_step(input logic [7:0] x, output bit produced,
                                        output pix_out_t r);
    int unsigned p, col, row_len, rows_n;
    int          a, b, c, pa, pb, pc, pick;
    logic [7:0]  pix;
    bit          row_end, img_end;
    produced = 1'b0;
    r        = '0;
    if (want_type) begin
      filt       = (x <= 8'd4) ? psu_pkg::filt_t'(x[2:0]) : psu_pkg::FILT_NONE;
      want_type  = 1'b0;
      col_idx    = 0;
      left_hist  = '0;
      above_hist = '0;
      return;
    end
    p       = (cfg_pix == 0) ? 1 : ((cfg_pix > psu_pkg::MAX_PIXEL_BYTES) ?
                                    psu_pkg::MAX_PIXEL_BYTES : cfg_pix);
    row_len = (cfg_row == 0) ? 1 : ((cfg_row > psu_pkg::MAX_ROW_BYTES) ?
                                    psu_pkg::MAX_ROW_BYTES : cfg_row);
    rows_n  = (cfg_rows == 0) ? 1 : cfg_rows;
    col     = (col_idx >= psu_pkg::MAX_ROW_BYTES) ? psu_pkg::MAX_ROW_BYTES - 1 : col_idx;

    a = int'((left_hist >> (8 * (p - 1))) & 64'hFF);
    c = int'((above_hist >> (8 * (p - 1))) & 64'hFF);
    b = (row_idx > 0) ? int'(line_store[col]) : 0;

    // Paeth: nearest of a, b, c to a + b - c, ties broken a, then b.
    pa = b - c;
    pb = a - c;
    pc = a + b - 2 * c;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    pick = (pa <= pb && pa <= pc) ? a : ((pb <= pc) ? b : c);

    case (filt)
      psu_pkg::FILT_SUB:   pix = 8'(int'(x) + a);
      psu_pkg::FILT_UP:    pix = 8'(int'(x) + b);
      psu_pkg::FILT_AVG:   pix = 8'(int'(x) + ((a + b) >> 1));
      psu_pkg::FILT_PAETH: pix = 8'(int'(x) + pick);
      default:             pix = x;
    endcase

    line_store[col] = pix;
    if (col + 1 > store_filled) store_filled = col + 1;
    left_hist  = {left_hist[55:0], pix};
    above_hist = {above_hist[55:0], 8'(b)};

    row_end = (col + 1 >= row_len);
    img_end = row_end && (row_idx + 1 >= rows_n);
    if (row_end) begin
      want_type = 1'b1;
      col_idx   = 0;
      row_idx   = img_end ? 0 : ((row_idx + 1) & 32'hFFFF);
    end else begin
      col_idx = col + 1;
    end
    produced = 1'b1;
    r        = '{pix: pix, eor: row_end, loi: img_end};
  endfunction

  // Random stream content: at a row start mostly legal filter codes with some
  // unknown ones, elsewhere random bytes leaning on the extremes.
  function automatic logic [7:0] stream_byte();
    if (want_type)
      return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 255)) : 8'($urandom_range(0, 4));
    if ($urandom_range(0, 7) == 0)
      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic set_mode(input idle_mode_t m);
    case (m)
      IDLE_SEND: tx_pct = 72;
      IDLE_BOTH: tx_pct = 37;
      default:   tx_pct = 0;
    endcase
    rx_mode <= m;
  endtask

  // Offer one request, hold it until taken, then predict. A typed result,
  // when given, stands in for the predicted one.
  task automatic feed_byte(input logic [7:0] x, input bit typed, input pix_out_t typed_res);
    bit       produced;
    pix_out_t r;
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_filtered_byte <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    unfilter_step(x, produced, r);
    if (produced) pending_pixels.push_back(typed ? typed_res : r);
  endtask

  // Register writes only with the pipeline empty: all results back, then
  // SETTLE_CYCLES more so a trailing type byte has settled too.
  task automatic write_reg(input logic [psu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psu_pkg::CFG_W-1:0] d);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      psu_pkg::CFG_PIXEL_BYTES: cfg_pix  = d[3:0];
      psu_pkg::CFG_ROW_BYTES:   cfg_row  = d[psu_pkg::ROWLEN_W-1:0];
      psu_pkg::CFG_IMAGE_ROWS:  cfg_rows = d[psu_pkg::ROWS_W-1:0];
      default: ;  // unused index, no effect
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Receiver: random stalls per mode; on entering the hold mode it refuses
  // results for a long stretch so the queue fills and in_stall rises.
  initial begin : rx_side
    idle_mode_t seen;
    int         hold_left;
    int         pct;
    out_stall = 1'b0;
    seen      = IDLE_NONE;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_mode == IDLE_HOLD && seen != IDLE_HOLD) hold_left = HOLD_CYCLES;
      seen = rx_mode;
      pct  = (rx_mode == IDLE_RECV) ? 72 : ((rx_mode == IDLE_BOTH) ? 37 : 0);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("result with nothing expected: pixel_byte %h", out_pixel_byte);
        fault_count++;
      end else begin
        due_pixel = pending_pixels.pop_front();
        if (out_pixel_byte !== due_pixel.pix) begin
          $error("pixel_byte: expected %h, got %h", due_pixel.pix, out_pixel_byte);
          fault_count++;
        end
        if (out_end_of_row !== due_pixel.eor) begin
          $error("end_of_row: expected %b, got %b", due_pixel.eor, out_end_of_row);
          fault_count++;
        end
        if (out_last_of_image !== due_pixel.loi) begin
          $error("last_of_image: expected %b, got %b", due_pixel.loi, out_last_of_image);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: ends a run that stops moving requests.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL png_scanline_unfilter_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim
    int i;
    int n;
    int k;
    int phase;
    int rnd_items;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_filtered_byte = '0;
    rx_mode          = IDLE_NONE;
    tx_pct           = 0;
    fault_count      = 0;
    quiet_cycles     = 0;
    left_hist        = '0;
    above_hist       = '0;
    col_idx          = 0;
    row_idx          = 0;
    filt             = psu_pkg::FILT_NONE;
    want_type        = 1'b1;
    store_filled     = 0;
    cfg_pix          = psu_pkg::RST_PIXEL_BYTES;
    cfg_row          = psu_pkg::RST_ROW_BYTES;
    cfg_rows         = psu_pkg::RST_IMAGE_ROWS;

    // Directed stimulus. Typed results follow straight from the filter rules;
    // Average and Paeth rows go through the predictor.
    dir_tab = '{
      // Reset config (4-byte pixels, 1024-byte rows, one row): Sub row; byte 5
      // and 6 reach back four bytes.
      '{ST_BYTE,    '0, '0, 8'(psu_pkg::FILT_SUB), '0},
      '{ST_CHECKED, '0, '0, 8'h10, {8'h10, 1'b0, 1'b0}},
      '{ST_CHECKED, '0, '0, 8'h20, {8'h20, 1'b0, 1'b0}},
      '{ST_CHECKED, '0, '0, 8'h30, {8'h30, 1'b0, 1'b0}},
      '{ST_CHECKED, '0, '0, 8'hFF, {8'hFF, 1'b0, 1'b0}},
      '{ST_CHECKED, '0, '0, 8'h05, {8'h15, 1'b0, 1'b0}},
      // Shorten the row mid-row: the next byte closes row and image.
      '{ST_CFG,     psu_pkg::CFG_ROW_BYTES, 16'd6, '0, '0},
      '{ST_CHECKED, '0, '0, 8'hFF, {8'h1F, 1'b1, 1'b1}},
      // All-zero registers act as 1; unknown filter acts as None.
      '{ST_CFG,     psu_pkg::CFG_PIXEL_BYTES, 16'd0, '0, '0},
      '{ST_CFG,     psu_pkg::CFG_ROW_BYTES,   16'd0, '0, '0},
      '{ST_CFG,     psu_pkg::CFG_IMAGE_ROWS,  16'd0, '0, '0},
      '{ST_BYTE,    '0, '0, UNKNOWN_FILT, '0},
      '{ST_CHECKED, '0, '0, 8'hC3, {8'hC3, 1'b1, 1'b1}},
      // 2-byte rows, three rows: Sub wraps, then Average and Paeth read above.
      '{ST_CFG,     psu_pkg::CFG_ROW_BYTES,  16'd2, '0, '0},
      '{ST_CFG,     psu_pkg::CFG_IMAGE_ROWS, 16'd3, '0, '0},
      '{ST_BYTE,    '0, '0, 8'(psu_pkg::FILT_SUB), '0},
      '{ST_CHECKED, '0, '0, 8'h40, {8'h40, 1'b0, 1'b0}},
      '{ST_CHECKED, '0, '0, 8'hC0, {8'h00, 1'b1, 1'b0}},
      '{ST_BYTE,    '0, '0, 8'(psu_pkg::FILT_AVG), '0},
      '{ST_BYTE,    '0, '0, 8'h01, '0},
      '{ST_BYTE,    '0, '0, 8'h02, '0},
      '{ST_BYTE,    '0, '0, 8'(psu_pkg::FILT_PAETH), '0},
      '{ST_BYTE,    '0, '0, 8'h80, '0},
      '{ST_BYTE,    '0, '0, 8'h7F, '0},
      // Oversized pixel clamps to 8; row and image size changed mid-image.
      '{ST_CFG,     psu_pkg::CFG_PIXEL_BYTES, 16'd15, '0, '0},
      '{ST_CFG,     psu_pkg::CFG_ROW_BYTES,   16'd3,  '0, '0},
      '{ST_CFG,     psu_pkg::CFG_IMAGE_ROWS,  16'd2,  '0, '0},
      '{ST_BYTE,    '0, '0, 8'(psu_pkg::FILT_NONE), '0},
      '{ST_CHECKED, '0, '0, 8'h01, {8'h01, 1'b0, 1'b0}},
      '{ST_CHECKED, '0, '0, 8'h02, {8'h02, 1'b0, 1'b0}},
      '{ST_CFG,     psu_pkg::CFG_ROW_BYTES, 16'd2, '0, '0},
      '{ST_CHECKED, '0, '0, 8'h03, {8'h03, 1'b1, 1'b0}},
      '{ST_CFG,     psu_pkg::CFG_IMAGE_ROWS, 16'd1, '0, '0},
      '{ST_BYTE,    '0, '0, 8'(psu_pkg::FILT_UP), '0},
      '{ST_CHECKED, '0, '0, 8'hFF, {8'h00, 1'b0, 1'b0}},
      '{ST_CHECKED, '0, '0, 8'h00, {8'h02, 1'b1, 1'b1}},
      // Write to the unused index: must change nothing.
      '{ST_CFG,     CFG_UNUSED_IDX, 16'hFFFF, '0, '0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      case (dir_tab[i].kind)
        ST_CFG:     write_reg(dir_tab[i].idx, dir_tab[i].wdata);
        ST_CHECKED: feed_byte(dir_tab[i].din, 1'b1, dir_tab[i].res);
        default:    feed_byte(dir_tab[i].din, 1'b0, '0);
      endcase
    end

    // Random phases, rotating through the idle modes including the hold-off.
    // Mid-image (row above in use) the row length never exceeds the part of
    // the line store that has been written.
    rnd_items = 0;
    for (phase = 0; rnd_items < RANDOM_ITEMS; phase++) begin
      if (phase == 0 || $urandom_range(0, 2) != 0)
        write_reg(psu_pkg::CFG_PIXEL_BYTES, 16'($urandom_range(0, 15)));
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        if (row_idx != 0)
          n = $urandom_range(1, (store_filled < 24) ? store_filled : 24);
        else if ($urandom_range(0, 7) == 0)
          n = 0;
        else
          n = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 12);
        write_reg(psu_pkg::CFG_ROW_BYTES, 16'(n));
      end
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        k = $urandom_range(0, 9);
        write_reg(psu_pkg::CFG_IMAGE_ROWS, (k == 0) ? 16'hFFFF : ((k == 1) ? 16'd0 :
                                            16'($urandom_range(1, 6))));
      end
      set_mode(idle_mode_t'(phase % 5));
      n = $urandom_range(40, 80);
      for (i = 0; i < n; i++) begin
        feed_byte(stream_byte(), 1'b0, '0);
        rnd_items++;
      end
    end

    // Oversized row length saturates, so a short burst stays inside one row;
    // a one-byte row length then closes row and image.
    set_mode(IDLE_NONE);
    write_reg(psu_pkg::CFG_IMAGE_ROWS, 16'd1);
    while (!(want_type && row_idx == 0)) feed_byte(stream_byte(), 1'b0, '0);
    write_reg(psu_pkg::CFG_ROW_BYTES, 16'h7FFF);
    write_reg(psu_pkg::CFG_PIXEL_BYTES, 16'($urandom_range(0, 15)));
    for (i = 0; i < 24; i++) feed_byte(stream_byte(), 1'b0, '0);
    write_reg(psu_pkg::CFG_ROW_BYTES, 16'd1);
    do
      feed_byte(stream_byte(), 1'b0, '0);
    while (!(want_type && row_idx == 0));

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("PASS png_scanline_unfilter_core");
    else
      $display("FAIL png_scanline_unfilter_core");
    $finish;
  end

endmodule
